@@ hdl/azimuth_limit_homing_pulse_controller_unit_macros.svh @@
// Assertion macros for the azimuth controller checker.
// Each macro expects clk in the scope where it is used, and ALHPC_ASSERT also rst_n.
`ifndef AZIMUTH_LIMIT_HOMING_PULSE_CONTROLLER_UNIT_MACROS_SVH
`define AZIMUTH_LIMIT_HOMING_PULSE_CONTROLLER_UNIT_MACROS_SVH

// Check a property only while out of reset.
`define ALHPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define ALHPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/alhpc_pkg.sv @@
package alhpc_pkg;

  // Default width of the phase timer
  localparam int TIME_WIDTH_DEF = 16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ON   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_ON    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_OFF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WEST = 3'd4;

  // Configuration reset values
  localparam logic [15:0] FIRST_ON_RST   = 16'd1000;
  localparam logic [15:0] STEP_ON_RST    = 16'd200;
  localparam logic [15:0] STEP_OFF_RST   = 16'd300;
  localparam logic        ACTIVE_LOW_RST = 1'b1;
  localparam logic        FIRST_WEST_RST = 1'b0;

  // Commands
  localparam logic [3:0] CMD_TICK       = 4'd0;
  localparam logic [3:0] CMD_STOP       = 4'd1;
  localparam logic [3:0] CMD_EAST_ON    = 4'd2;
  localparam logic [3:0] CMD_WEST_ON    = 4'd3;
  localparam logic [3:0] CMD_PULSE_E    = 4'd4;
  localparam logic [3:0] CMD_PULSE_W    = 4'd5;
  localparam logic [3:0] CMD_STEP_E     = 4'd6;
  localparam logic [3:0] CMD_STEP_W     = 4'd7;
  localparam logic [3:0] CMD_HOME       = 4'd8;
  localparam logic [3:0] CMD_ABORT      = 4'd9;
  localparam logic [3:0] CMD_DRIVE_NONE = 4'd10;
  localparam logic [3:0] CMD_DRIVE_E    = 4'd11;
  localparam logic [3:0] CMD_DRIVE_W    = 4'd12;
  localparam logic [3:0] CMD_MANUAL_E   = 4'd13;
  localparam logic [3:0] CMD_MANUAL_W   = 4'd14;
  localparam logic [3:0] CMD_INIT       = 4'd15;

  // Direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_EAST = 2'd1;
  localparam logic [1:0] DIR_WEST = 2'd2;

  // Run mode codes
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_SINGLE  = 2'd1;
  localparam logic [1:0] MODE_STEPPED = 2'd2;

  // Controller state apart from the phase timer
  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] on_time;
    logic        drv;
    logic [1:0]  mdir;
    logic [15:0] cnt;
    logic        hbusy;
    logic        hdone;
    logic        hfail;
    logic [1:0]  sdir;
    logic        lacc;
    logic        pin_e;
    logic        pin_w;
  } alhpc_state_t;

endpackage

@@ hdl/alhpc_if.sv @@
// Command channel
interface alhpc_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic        hall_center_raw;
  logic        hall_eastpin_raw;
  logic        hall_westpin_raw;
  logic [15:0] pulse_ms;

  modport source (output valid, command, hall_center_raw, hall_eastpin_raw,
                  hall_westpin_raw, pulse_ms, input ready);
  modport sink (input valid, command, hall_center_raw, hall_eastpin_raw,
                hall_westpin_raw, pulse_ms, output ready);
endinterface

// Status channel
interface alhpc_out_if;
  logic        valid;
  logic        ready;
  logic        pin_east_drive;
  logic        pin_west_drive;
  logic [1:0]  run_mode;
  logic        output_active;
  logic [1:0]  direction;
  logic [15:0] step_count;
  logic        homing_busy;
  logic        is_homed;
  logic        homing_error;
  logic        accepted;
  logic [2:0]  sensor_flags;
  logic [15:0] on_time_ms;

  modport source (output valid, pin_east_drive, pin_west_drive, run_mode, output_active,
                  direction, step_count, homing_busy, is_homed, homing_error, accepted,
                  sensor_flags, on_time_ms, input ready);
  modport sink (input valid, pin_east_drive, pin_west_drive, run_mode, output_active,
                direction, step_count, homing_busy, is_homed, homing_error, accepted,
                sensor_flags, on_time_ms, output ready);
endinterface

@@ hdl/azimuth_limit_homing_pulse_controller_unit.sv @@
// Channel   Port     Role    Carries
// command   in_ch    sink    command, three raw hall levels, pulse length
// status    out_ch   source  relay pins, run/homing status, sensor flags, on time
//
// One command is taken per cycle while intake is not stalled; its status appears in the
// output register in the next cycle. The controller state and the output register update
// on the same edge, so the rate is one item per cycle.
// A held output stalls intake only while the output register is full and not taken.
// rst_n is synchronous: it clears the state, the output valid and loads config defaults.
module azimuth_limit_homing_pulse_controller_unit #(
  parameter int TIME_WIDTH = alhpc_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  alhpc_in_if.sink                       in_ch,
  alhpc_out_if.source                    out_ch,
  input  logic                           cfg_we,
  input  logic [alhpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_wdata
);
  import alhpc_pkg::*;

  localparam int CMP_W = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;

  logic [15:0]           first_on_r, step_on_r, step_off_r;
  logic                  active_low_r, first_west_r;
  alhpc_state_t          st_r, st_nxt;
  logic [TIME_WIDTH-1:0] el_r, el_nxt;
  logic                  cen, elim, wlim;
  logic                  in_xfer;
  logic                  out_valid_r;
  alhpc_state_t          res_r;
  logic [2:0]            flags_r;

  function automatic logic f_blocked(input logic [1:0] d, input logic el, input logic wl);
    return ((d == DIR_EAST) && el) || ((d == DIR_WEST) && wl);
  endfunction

  function automatic alhpc_state_t f_reset_motion(input alhpc_state_t s_in);
    alhpc_state_t t;
    t = s_in;
    t.pin_e = 1'b0;
    t.pin_w = 1'b0;
    t.mode = MODE_IDLE;
    t.drv = 1'b0;
    t.on_time = '0;
    t.mdir = DIR_NONE;
    return t;
  endfunction

  function automatic alhpc_state_t f_set_pins(input alhpc_state_t s_in, input logic [1:0] d,
                                              input logic chk, input logic el, input logic wl);
    alhpc_state_t t;
    t = s_in;
    if ((d == DIR_EAST) && !(chk && el)) begin
      t.pin_e = 1'b0;
      t.pin_w = 1'b1;
    end else if ((d == DIR_WEST) && !(chk && wl)) begin
      t.pin_e = 1'b1;
      t.pin_w = 1'b0;
    end else begin
      t.pin_e = 1'b0;
      t.pin_w = 1'b0;
    end
    return t;
  endfunction

  // Start a single or stepped run; the caller clears the timer on success
  function automatic logic f_start(input alhpc_state_t s_in, input logic [1:0] d,
                                   input logic [1:0] m, input logic [15:0] ont,
                                   input logic el, input logic wl,
                                   output alhpc_state_t s_out);
    alhpc_state_t t;
    logic         ok;
    t = f_reset_motion(s_in);
    ok = !f_blocked(d, el, wl);
    if (ok) begin
      t.mode = m;
      t.mdir = d;
      t.cnt = '0;
      t.drv = 1'b1;
      t.on_time = ont;
      t = f_set_pins(t, d, 1'b1, el, wl);
    end
    s_out = t;
    return ok;
  endfunction

  // Qualify sensors; the east-named pin is the logical west limit
  assign cen  = active_low_r ? !in_ch.hall_center_raw  : in_ch.hall_center_raw;
  assign wlim = active_low_r ? !in_ch.hall_eastpin_raw : in_ch.hall_eastpin_raw;
  assign elim = active_low_r ? !in_ch.hall_westpin_raw : in_ch.hall_westpin_raw;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Next state for one command
  always_comb begin : p_next
    alhpc_state_t          s;
    alhpc_state_t          t;
    logic [TIME_WIDTH-1:0] el;
    logic                  ok;
    logic [1:0]            first;
    logic [1:0]            other;
    s = st_r;
    t = st_r;
    el = el_r;
    ok = 1'b0;
    first = first_west_r ? DIR_WEST : DIR_EAST;
    other = first_west_r ? DIR_EAST : DIR_WEST;
    case (in_ch.command)
      CMD_TICK: begin
        if (el != '1) el = el + 1'b1;
        if (s.hbusy && cen) begin
          s = f_reset_motion(s);
          s.hbusy = 1'b0;
          s.hdone = 1'b1;
          s.hfail = 1'b0;
          s.sdir = DIR_NONE;
        end else if ((s.mdir == DIR_EAST) && elim) begin
          if (s.hbusy && (s.sdir == DIR_EAST)) begin
            ok = f_start(s, DIR_WEST, MODE_STEPPED, first_on_r, elim, wlim, t);
            s = t;
            if (ok) begin
              s.sdir = DIR_WEST;
              el = '0;
            end else begin
              s.hbusy = 1'b0;
              s.hfail = 1'b1;
              s.sdir = DIR_NONE;
            end
          end else begin
            s = f_reset_motion(s);
          end
        end else if ((s.mdir == DIR_WEST) && wlim) begin
          s = f_reset_motion(s);
          if (s.hbusy && (s.sdir == DIR_WEST)) begin
            s.hbusy = 1'b0;
            s.hfail = 1'b1;
            s.sdir = DIR_NONE;
          end
        end else if (s.mode != MODE_IDLE) begin
          if (s.drv) begin
            // End the on phase
            if (CMP_W'(el) >= CMP_W'(s.on_time)) begin
              s.pin_e = 1'b0;
              s.pin_w = 1'b0;
              s.drv = 1'b0;
              el = '0;
              if (s.cnt != 16'hFFFF) s.cnt = s.cnt + 16'd1;
              if (s.mode == MODE_SINGLE) begin
                s.mode = MODE_IDLE;
                s.mdir = DIR_NONE;
                s.on_time = '0;
              end
            end
          end else if ((s.mode == MODE_STEPPED) &&
                       (CMP_W'(el) >= CMP_W'(step_off_r))) begin
            // Start the next stepped pulse
            s.drv = 1'b1;
            el = '0;
            s.on_time = step_on_r;
            s = f_set_pins(s, s.mdir, 1'b1, elim, wlim);
          end
        end
      end
      CMD_STOP, CMD_ABORT: begin
        s = f_reset_motion(s);
        s.hbusy = 1'b0;
        s.sdir = DIR_NONE;
      end
      CMD_EAST_ON, CMD_WEST_ON: begin
        first = (in_ch.command == CMD_EAST_ON) ? DIR_EAST : DIR_WEST;
        if (f_blocked(first, elim, wlim)) begin
          s = f_reset_motion(s);
          s.lacc = 1'b0;
        end else begin
          s.mdir = first;
          s = f_set_pins(s, first, 1'b1, elim, wlim);
          s.lacc = 1'b1;
        end
      end
      CMD_PULSE_E, CMD_PULSE_W: begin
        s.hbusy = 1'b0;
        s.sdir = DIR_NONE;
        first = (in_ch.command == CMD_PULSE_E) ? DIR_EAST : DIR_WEST;
        ok = f_start(s, first, MODE_SINGLE, in_ch.pulse_ms, elim, wlim, t);
        s = t;
        s.lacc = ok;
        if (ok) el = '0;
      end
      CMD_STEP_E, CMD_STEP_W: begin
        s.hbusy = 1'b0;
        s.sdir = DIR_NONE;
        first = (in_ch.command == CMD_STEP_E) ? DIR_EAST : DIR_WEST;
        ok = f_start(s, first, MODE_STEPPED, first_on_r, elim, wlim, t);
        s = t;
        s.lacc = ok;
        if (ok) el = '0;
      end
      CMD_HOME: begin
        s = f_reset_motion(s);
        s.hbusy = 1'b0;
        s.hdone = 1'b0;
        s.hfail = 1'b0;
        s.sdir = DIR_NONE;
        if (cen) begin
          s.hdone = 1'b1;
        end else begin
          s.hbusy = 1'b1;
          ok = f_start(s, first, MODE_STEPPED, first_on_r, elim, wlim, t);
          if (ok) begin
            s = t;
            s.sdir = first;
            el = '0;
          end else begin
            ok = f_start(s, other, MODE_STEPPED, first_on_r, elim, wlim, t);
            s = t;
            if (ok) begin
              s.sdir = other;
              el = '0;
            end else begin
              s.hbusy = 1'b0;
              s.hfail = 1'b1;
            end
          end
        end
      end
      CMD_DRIVE_NONE, CMD_DRIVE_E, CMD_DRIVE_W: begin
        first = (in_ch.command == CMD_DRIVE_E) ? DIR_EAST :
                (in_ch.command == CMD_DRIVE_W) ? DIR_WEST : DIR_NONE;
        if ((first == DIR_NONE) || f_blocked(first, elim, wlim)) begin
          s = f_reset_motion(s);
          s.lacc = 1'b0;
        end else begin
          s.mode = MODE_IDLE;
          s.mdir = first;
          s.drv = 1'b1;
          s.on_time = '0;
          s = f_set_pins(s, first, 1'b1, elim, wlim);
          s.lacc = 1'b1;
        end
      end
      CMD_MANUAL_E, CMD_MANUAL_W: begin
        first = (in_ch.command == CMD_MANUAL_E) ? DIR_EAST : DIR_WEST;
        s.mode = MODE_IDLE;
        s.mdir = first;
        s.drv = 1'b1;
        s.on_time = '0;
        s = f_set_pins(s, first, 1'b0, elim, wlim);
        s.lacc = 1'b1;
      end
      default: begin
        // Init: drop motion and all homing flags
        s = f_reset_motion(s);
        s.hbusy = 1'b0;
        s.hdone = 1'b0;
        s.hfail = 1'b0;
        s.sdir = DIR_NONE;
      end
    endcase
    st_nxt = s;
    el_nxt = el;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_on_r   <= FIRST_ON_RST;
      step_on_r    <= STEP_ON_RST;
      step_off_r   <= STEP_OFF_RST;
      active_low_r <= ACTIVE_LOW_RST;
      first_west_r <= FIRST_WEST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_ON:   first_on_r   <= cfg_wdata;
        CFG_STEP_ON:    step_on_r    <= cfg_wdata;
        CFG_STEP_OFF:   step_off_r   <= cfg_wdata;
        CFG_ACTIVE_LOW: active_low_r <= cfg_wdata[0];
        CFG_FIRST_WEST: first_west_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Advance controller state on each command transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{mode: MODE_IDLE, on_time: '0, drv: 1'b0, mdir: DIR_NONE, cnt: '0,
                hbusy: 1'b0, hdone: 1'b0, hfail: 1'b0, sdir: DIR_NONE, lacc: 1'b0,
                pin_e: 1'b0, pin_w: 1'b0};
      el_r <= '0;
    end else if (in_xfer) begin
      st_r <= st_nxt;
      el_r <= el_nxt;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold status payload until the next transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r   <= st_nxt;
      flags_r <= {wlim, elim, cen};
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.pin_east_drive = res_r.pin_e;
  assign out_ch.pin_west_drive = res_r.pin_w;
  assign out_ch.run_mode       = res_r.mode;
  assign out_ch.output_active  = res_r.drv;
  assign out_ch.direction      = res_r.mdir;
  assign out_ch.step_count     = res_r.cnt;
  assign out_ch.homing_busy    = res_r.hbusy;
  assign out_ch.is_homed       = res_r.hdone;
  assign out_ch.homing_error   = res_r.hfail;
  assign out_ch.accepted       = res_r.lacc;
  assign out_ch.sensor_flags   = flags_r;
  assign out_ch.on_time_ms     = res_r.on_time;

endmodule

@@ hdl/alhpc_checker.sv @@
`include "azimuth_limit_homing_pulse_controller_unit_macros.svh"

module alhpc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       pin_e,
  input logic       pin_w,
  input logic [1:0] direction,
  input logic       homing_busy,
  input logic       is_homed,
  input logic       homing_error
);
  import alhpc_pkg::*;

  `ALHPC_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "output valid after reset")
  `ALHPC_ASSERT(a_xfer_out, in_valid && in_ready |=> out_valid, "transfer lost its status")
  `ALHPC_ASSERT(a_pins_excl, out_valid |-> !(pin_e && pin_w), "both relay pins driven")
  `ALHPC_ASSERT(a_pin_dir, out_valid && (pin_e || pin_w) |-> (pin_w ? direction == DIR_EAST : direction == DIR_WEST), "relay pin disagrees with direction")
  `ALHPC_ASSERT(a_home_excl, out_valid && homing_busy |-> !is_homed && !homing_error, "homing busy with a final flag")

endmodule

bind azimuth_limit_homing_pulse_controller_unit alhpc_checker u_alhpc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .pin_e        (out_ch.pin_east_drive),
  .pin_w        (out_ch.pin_west_drive),
  .direction    (out_ch.direction),
  .homing_busy  (out_ch.homing_busy),
  .is_homed     (out_ch.is_homed),
  .homing_error (out_ch.homing_error)
);
